FILE: src/sexagesimal_text_to_angle_defines.svh
// Assertion macros used by the sexagesimal angle parser checker.
`ifndef SEXAGESIMAL_TEXT_TO_ANGLE_DEFINES_SVH
`define SEXAGESIMAL_TEXT_TO_ANGLE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SXA_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SXA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/sxa_pkg.sv
// Types, character codes and constant helpers for the sexagesimal angle parser.
package sxa_pkg;

    localparam int FRAC_DIGITS_DEF = 6;
    localparam int VALUE_BITS_DEF  = 48;
    localparam int ANGLE_W         = 48;
    localparam int NUM_PARTS       = 3;
    localparam int PART_W          = 2;
    localparam logic [PART_W-1:0] LAST_PART = PART_W'(NUM_PARTS - 1);

    // Character codes
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_POINT = 8'h2E;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_COLON = 8'h3A;

    // Field phase: skip before kind is sampled, skip with kind held,
    // parsing parts, ignoring text after the third colon.
    typedef enum logic [1:0] {
        PH_SKIP_NEW,
        PH_SKIP_HELD,
        PH_PARSE,
        PH_IGNORE
    } sxa_phase_t;

    typedef struct packed {
        logic [7:0] ch;
        logic       kind;
    } sxa_text_t;

    typedef struct packed {
        logic signed [ANGLE_W-1:0] angle;
        logic                      saturated;
        logic                      string_end;
    } sxa_result_t;

    // 10^k for elaboration-time constants
    function automatic longint unsigned pow10(int k);
        longint unsigned acc;
        acc = 64'd1;
        for (int i = 0; i < k; i++)
        begin
            acc = acc * 64'd10;
        end
        return acc;
    endfunction

    // Weight of degrees/hours, minutes, seconds in seconds
    function automatic longint unsigned part_weight(int idx);
        longint unsigned w;
        case (idx)
            0:       w = 64'd3600;
            1:       w = 64'd60;
            default: w = 64'd1;
        endcase
        return w;
    endfunction

    function automatic logic is_terminator(logic [7:0] c);
        return (c == CH_NUL) || (c == CH_SPACE) || (c == CH_COMMA);
    endfunction

endpackage

FILE: src/sexagesimal_text_to_angle.sv
// Streaming sexagesimal angle text parser, one character per beat.
//
//   channel | dir | payload       | beat
//   --------+-----+---------------+-----------------------------------------
//   text    | in  | sxa_text_t    | one character and its kind bit
//   result  | out | sxa_result_t  | one fixed-point angle per ended field
//
// Takes one character per cycle while text_ready is high. A field's result
// passes from its ending character through the finish stage (sign, scale
// by 15, clamp) and then the output register.
// text_ready falls only when both the finish stage and the output register
// hold results and result_ready is low.
// Reset clears all field state, the held kind and the valid flags of both result stages.
module sexagesimal_text_to_angle
    import sxa_pkg::*;
#(
    parameter int FRAC_DIGITS = FRAC_DIGITS_DEF,
    parameter int VALUE_BITS  = VALUE_BITS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        text_valid,
    output logic        text_ready,
    input  sxa_text_t   text,
    output logic        result_valid,
    input  logic        result_ready,
    output sxa_result_t result
);

    localparam longint unsigned LIMIT = (64'd1 << (VALUE_BITS - 1)) - 64'd1;
    localparam int WIDE_W     = VALUE_BITS + 4;
    localparam int FRAC_W     = $clog2(64'd3600 * pow10(FRAC_DIGITS));
    localparam int FRAC_CMP_W = (FRAC_W > VALUE_BITS) ? FRAC_W : VALUE_BITS;
    localparam int FD_W       = $clog2(FRAC_DIGITS + 1);
    localparam int FD_IDX_W   = (FRAC_DIGITS > 1) ? $clog2(FRAC_DIGITS) : 1;

    localparam logic [VALUE_BITS-1:0]        LIMIT_V  = VALUE_BITS'(LIMIT);
    localparam logic [WIDE_W-1:0]            LIMIT_W  = WIDE_W'(LIMIT);
    localparam logic [FRAC_CMP_W-1:0]        LIMIT_F  = FRAC_CMP_W'(LIMIT);
    localparam logic signed [VALUE_BITS-1:0] RT_MAX   = VALUE_BITS'(LIMIT);
    localparam logic signed [VALUE_BITS-1:0] RT_MIN   = -RT_MAX;
    localparam logic signed [VALUE_BITS:0]   SUM_MAX  = (VALUE_BITS + 1)'(LIMIT);
    localparam logic signed [VALUE_BITS:0]   SUM_MIN  = -SUM_MAX;
    localparam logic [FD_W-1:0]              FD_LAST  = FD_W'(FRAC_DIGITS);

    // Field state
    sxa_phase_t                    phase_reg, phase_next;
    logic                          kind_reg, kind_next;
    logic [PART_W-1:0]             part_reg, part_next;
    logic                          field_neg_reg, field_neg_next;
    logic                          part_neg_reg, part_neg_next;
    logic                          started_reg, started_next;
    logic [VALUE_BITS-1:0]         whole_reg, whole_next;
    logic                          whole_big_reg, whole_big_next;
    logic [FRAC_W-1:0]             frac_reg, frac_next;
    logic [FD_W-1:0]               fd_reg, fd_next;
    logic                          point_reg, point_next;
    logic                          stopped_reg, stopped_next;
    logic                          colon_reg, colon_next;
    logic signed [VALUE_BITS-1:0]  rt_reg, rt_next;
    logic                          clip_reg, clip_next;

    // Finish stage
    logic                          fin_valid_reg, fin_valid_next;
    logic signed [VALUE_BITS-1:0]  fin_rt_reg, fin_rt_next;
    logic                          fin_neg_reg, fin_neg_next;
    logic                          fin_scale_reg, fin_scale_next;
    logic                          fin_clip_reg, fin_clip_next;
    logic                          fin_nul_reg, fin_nul_next;

    // Output register
    logic                          result_valid_reg, result_valid_next;
    sxa_result_t                   result_reg, result_next;

    // Per-part constant tables
    logic [VALUE_BITS-1:0]         whole_unit [NUM_PARTS];
    logic                          unit_clip  [NUM_PARTS];
    logic [FRAC_W-1:0]             frac_step  [NUM_PARTS][FRAC_DIGITS];

    for (genvar p = 0; p < NUM_PARTS; p++)
    begin : g_part
        localparam longint unsigned SCALE = part_weight(p) * pow10(FRAC_DIGITS);
        assign whole_unit[p] = VALUE_BITS'((SCALE > LIMIT) ? LIMIT : SCALE);
        assign unit_clip[p]  = (SCALE > LIMIT);
        for (genvar k = 0; k < FRAC_DIGITS; k++)
        begin : g_digit
            assign frac_step[p][k] =
                FRAC_W'(part_weight(p) * pow10(FRAC_DIGITS - 1 - k));
        end
    end

    // Character decode
    logic       accept, in_skip, kind_now;
    logic       is_nul, is_term, is_colon, is_minus, is_plus, is_point;
    logic       is_digit, is_ws, skip_char, finish_char, parse_char, close_char;
    logic [3:0] digit;

    assign accept      = text_valid && text_ready;
    assign is_nul      = (text.ch == CH_NUL);
    assign is_term     = is_terminator(text.ch);
    assign is_colon    = (text.ch == CH_COLON);
    assign is_minus    = (text.ch == CH_MINUS);
    assign is_plus     = (text.ch == CH_PLUS);
    assign is_point    = (text.ch == CH_POINT);
    assign is_digit    = text.ch inside {[CH_0:CH_9]};
    assign is_ws       = text.ch inside {[CH_TAB:CH_CR]};
    assign digit       = text.ch[3:0];
    assign in_skip     = (phase_reg == PH_SKIP_NEW) || (phase_reg == PH_SKIP_HELD);
    assign kind_now    = (phase_reg == PH_SKIP_NEW) ? text.kind : kind_reg;
    assign skip_char   = in_skip && ((text.ch == CH_SPACE) || ((text.ch == CH_COMMA) && kind_now));
    assign finish_char = is_term && !skip_char;
    assign parse_char  = (phase_reg == PH_PARSE) || (in_skip && !is_term && !is_minus);
    assign close_char  = parse_char && (is_term || is_colon);

    // Whole digits: scaled value times ten plus digit times the part unit
    logic [WIDE_W-1:0] unit_w, whole_w, digit_whole, whole_acc;
    logic              whole_over;

    assign unit_w      = WIDE_W'(whole_unit[part_reg]);
    assign whole_w     = WIDE_W'(whole_reg);
    assign digit_whole = (digit[0] ? unit_w : '0) + (digit[1] ? (unit_w << 1) : '0)
                       + (digit[2] ? (unit_w << 2) : '0) + (digit[3] ? (unit_w << 3) : '0);
    assign whole_acc   = (whole_w << 3) + (whole_w << 1) + digit_whole;
    assign whole_over  = (whole_acc > LIMIT_W);

    // Fraction digits: add digit times the weight of this decimal place
    logic [FRAC_W-1:0] step_sel, frac_add;

    assign step_sel = frac_step[part_reg][fd_reg[FD_IDX_W-1:0]];
    assign frac_add = (digit[0] ? step_sel : '0) + (digit[1] ? (step_sel << 1) : '0)
                    + (digit[2] ? (step_sel << 2) : '0) + (digit[3] ? (step_sel << 3) : '0);

    // Close a part: saturate whole and fraction units, add into the total
    logic [VALUE_BITS-1:0]        whole_units, frac_units, part_mag;
    logic [VALUE_BITS:0]          mag_sum;
    logic                         frac_over, mag_over;
    logic signed [VALUE_BITS:0]   delta, rt_sum;
    logic signed [VALUE_BITS-1:0] rt_closed;
    logic                         clip_closed;

    assign whole_units = whole_big_reg ? LIMIT_V : whole_reg;
    assign frac_over   = (FRAC_CMP_W'(frac_reg) > LIMIT_F);
    assign frac_units  = frac_over ? LIMIT_V : VALUE_BITS'(frac_reg);
    assign mag_sum     = {1'b0, whole_units} + {1'b0, frac_units};
    assign mag_over    = (mag_sum > {1'b0, LIMIT_V});
    assign part_mag    = mag_over ? LIMIT_V : mag_sum[VALUE_BITS-1:0];
    assign delta       = part_neg_reg ? -$signed({1'b0, part_mag}) : $signed({1'b0, part_mag});
    assign rt_sum      = $signed({rt_reg[VALUE_BITS-1], rt_reg}) + delta;

    always_comb
    begin
        if (rt_sum > SUM_MAX)
        begin
            rt_closed = RT_MAX;
        end
        else if (rt_sum < SUM_MIN)
        begin
            rt_closed = RT_MIN;
        end
        else
        begin
            rt_closed = VALUE_BITS'(rt_sum);
        end
    end

    assign clip_closed = clip_reg || unit_clip[part_reg] || whole_big_reg || frac_over
                      || mag_over || (rt_sum > SUM_MAX) || (rt_sum < SUM_MIN);

    // Handshake between stages
    logic out_load;

    assign out_load   = fin_valid_reg && (!result_valid_reg || result_ready);
    assign text_ready = !fin_valid_reg || !result_valid_reg || result_ready;

    // Phase next state
    always_comb
    begin
        phase_next = phase_reg;
        if (accept)
        begin
            case (phase_reg)
                PH_SKIP_NEW, PH_SKIP_HELD:
                begin
                    if (skip_char)
                    begin
                        phase_next = PH_SKIP_HELD;
                    end
                    else if (is_term)
                    begin
                        phase_next = PH_SKIP_NEW;
                    end
                    else
                    begin
                        phase_next = PH_PARSE;
                    end
                end
                PH_PARSE:
                begin
                    if (is_term)
                    begin
                        phase_next = PH_SKIP_NEW;
                    end
                    else if (is_colon && (part_reg == LAST_PART))
                    begin
                        phase_next = PH_IGNORE;
                    end
                end
                PH_IGNORE:
                begin
                    if (is_term)
                    begin
                        phase_next = PH_SKIP_NEW;
                    end
                end
                default:
                begin
                    phase_next = PH_SKIP_NEW;
                end
            endcase
        end
    end

    // Field datapath and finish-stage load
    always_comb
    begin
        kind_next      = kind_reg;
        part_next      = part_reg;
        field_neg_next = field_neg_reg;
        part_neg_next  = part_neg_reg;
        started_next   = started_reg;
        whole_next     = whole_reg;
        whole_big_next = whole_big_reg;
        frac_next      = frac_reg;
        fd_next        = fd_reg;
        point_next     = point_reg;
        stopped_next   = stopped_reg;
        colon_next     = colon_reg;
        rt_next        = rt_reg;
        clip_next      = clip_reg;
        fin_valid_next = out_load ? 1'b0 : fin_valid_reg;
        fin_rt_next    = close_char ? rt_closed : rt_reg;
        fin_clip_next  = close_char ? clip_closed : clip_reg;
        fin_neg_next   = field_neg_reg;
        fin_scale_next = !kind_now && colon_reg;
        fin_nul_next   = is_nul;

        if (accept)
        begin
            if (phase_reg == PH_SKIP_NEW)
            begin
                kind_next = text.kind;
            end
            if (in_skip && is_minus)
            begin
                field_neg_next = 1'b1;
            end

            if (close_char)
            begin
                // part boundary: fold this part into the total
                rt_next        = rt_closed;
                clip_next      = clip_closed;
                part_neg_next  = 1'b0;
                started_next   = 1'b0;
                whole_next     = '0;
                whole_big_next = 1'b0;
                frac_next      = '0;
                fd_next        = '0;
                point_next     = 1'b0;
                stopped_next   = 1'b0;
                if (is_colon)
                begin
                    colon_next = 1'b1;
                    if (part_reg != LAST_PART)
                    begin
                        part_next = part_reg + 1'b1;
                    end
                end
            end
            else if (parse_char && !stopped_reg)
            begin
                // number syntax within a part
                if (!started_reg && is_ws)
                begin
                    started_next = 1'b0;
                end
                else if (!started_reg && (is_plus || is_minus))
                begin
                    started_next  = 1'b1;
                    part_neg_next = is_minus;
                end
                else if (is_digit)
                begin
                    started_next = 1'b1;
                    if (!point_reg)
                    begin
                        if (whole_over)
                        begin
                            whole_big_next = 1'b1;
                        end
                        else if (!whole_big_reg)
                        begin
                            whole_next = whole_acc[VALUE_BITS-1:0];
                        end
                    end
                    else if (fd_reg < FD_LAST)
                    begin
                        frac_next = frac_reg + frac_add;
                        fd_next   = fd_reg + 1'b1;
                    end
                end
                else if (is_point && !point_reg)
                begin
                    point_next   = 1'b1;
                    started_next = 1'b1;
                end
                else
                begin
                    stopped_next = 1'b1;
                end
            end

            if (finish_char)
            begin
                // field done: hand off and clear for the next field
                fin_valid_next = 1'b1;
                part_next      = '0;
                field_neg_next = 1'b0;
                part_neg_next  = 1'b0;
                started_next   = 1'b0;
                whole_next     = '0;
                whole_big_next = 1'b0;
                frac_next      = '0;
                fd_next        = '0;
                point_next     = 1'b0;
                stopped_next   = 1'b0;
                colon_next     = 1'b0;
                rt_next        = '0;
                clip_next      = 1'b0;
            end
        end
    end

    // Finish stage: sign, right ascension scale by 15, clamp
    logic                         fin_rt_neg, out_negative, scale_over;
    logic [VALUE_BITS-1:0]        fin_abs, out_mag;
    logic [WIDE_W-1:0]            times15;
    logic signed [VALUE_BITS-1:0] out_val;
    logic signed [63:0]           out_wide;

    assign fin_rt_neg   = fin_rt_reg[VALUE_BITS-1];
    assign fin_abs      = fin_rt_neg ? VALUE_BITS'(-fin_rt_reg) : VALUE_BITS'(fin_rt_reg);
    assign out_negative = fin_rt_neg ^ fin_neg_reg;
    assign times15      = (WIDE_W'(fin_abs) << 4) - WIDE_W'(fin_abs);
    assign scale_over   = fin_scale_reg && (times15 > LIMIT_W);
    assign out_mag      = !fin_scale_reg ? fin_abs
                        : (scale_over ? LIMIT_V : times15[VALUE_BITS-1:0]);
    assign out_val      = out_negative ? -$signed(out_mag) : $signed(out_mag);
    assign out_wide     = 64'(out_val);

    always_comb
    begin
        result_next            = result_reg;
        result_valid_next      = result_valid_reg && !result_ready;
        if (out_load)
        begin
            result_valid_next      = 1'b1;
            result_next.angle      = out_wide[ANGLE_W-1:0];
            result_next.saturated  = fin_clip_reg || scale_over;
            result_next.string_end = fin_nul_reg;
        end
    end

    // Control and field state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_SKIP_NEW;
            kind_reg         <= 1'b0;
            part_reg         <= '0;
            field_neg_reg    <= 1'b0;
            part_neg_reg     <= 1'b0;
            started_reg      <= 1'b0;
            whole_reg        <= '0;
            whole_big_reg    <= 1'b0;
            frac_reg         <= '0;
            fd_reg           <= '0;
            point_reg        <= 1'b0;
            stopped_reg      <= 1'b0;
            colon_reg        <= 1'b0;
            rt_reg           <= '0;
            clip_reg         <= 1'b0;
            fin_valid_reg    <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg        <= phase_next;
            kind_reg         <= kind_next;
            part_reg         <= part_next;
            field_neg_reg    <= field_neg_next;
            part_neg_reg     <= part_neg_next;
            started_reg      <= started_next;
            whole_reg        <= whole_next;
            whole_big_reg    <= whole_big_next;
            frac_reg         <= frac_next;
            fd_reg           <= fd_next;
            point_reg        <= point_next;
            stopped_reg      <= stopped_next;
            colon_reg        <= colon_next;
            rt_reg           <= rt_next;
            clip_reg         <= clip_next;
            fin_valid_reg    <= fin_valid_next;
            result_valid_reg <= result_valid_next;
        end
    end

    // Stage payloads
    always_ff @(posedge clk)
    begin
        if (accept && finish_char)
        begin
            fin_rt_reg    <= fin_rt_next;
            fin_neg_reg   <= fin_neg_next;
            fin_scale_reg <= fin_scale_next;
            fin_clip_reg  <= fin_clip_next;
            fin_nul_reg   <= fin_nul_next;
        end
        result_reg <= result_next;
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

FILE: src/sxa_checker.sv
// Port-level assertions for the sexagesimal angle parser and their bind.
`include "sexagesimal_text_to_angle_defines.svh"

module sxa_checker
    import sxa_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        text_valid,
    input logic        text_ready,
    input sxa_text_t   text,
    input logic        result_valid,
    input logic        result_ready,
    input sxa_result_t result
);

    // A stalled result beat stays put
    `SXA_ASSERT_NEXT(a_result_held, clk, rst_n, result_valid && !result_ready, result_valid && $stable(result), "result beat changed while stalled")

    // Input backpressure only when the output side is full and stalled
    `SXA_ASSERT_NOW(a_ready_low_only_when_full, clk, rst_n, !text_ready, result_valid && !result_ready, "text_ready low with room downstream")

    // A fresh result follows an accepted field terminator, with string_end set when that terminator was NUL
    `SXA_ASSERT_NOW(a_result_after_terminator, clk, rst_n, $rose(result_valid), $past(text_valid && text_ready, 2) && is_terminator($past(text.ch, 2)) && (result.string_end == ($past(text.ch, 2) == CH_NUL)), "result without matching terminator")

endmodule

bind sexagesimal_text_to_angle sxa_checker u_sxa_checker (.*);
